// ===== rtl/spdc_pkg.sv =====
// ----------------------------------------------------------------------------
// spdc_pkg
// Shared types, register indexes and count arithmetic for the sorted-position
// duplicate merge and cluster block.
// ----------------------------------------------------------------------------
`default_nettype none

package spdc_pkg;

   localparam int POS_W = 40;
   localparam int CNT_W = 24;
   localparam int WIN_W = 31;

   localparam int QUEUE_DEPTH = 8;
   localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
   localparam int MAX_PUSH    = 3;
   localparam int PUSH_W      = 2;

   localparam int CSR_IDX_W = 2;
   localparam logic [CSR_IDX_W-1:0] CSR_GATHER_WINDOW  = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_SEED_THRESHOLD = 2'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_GATHER_ENABLE  = 2'd2;

   localparam logic [CNT_W-1:0] CNT_MAX = '1;

   typedef struct packed {
      logic [POS_W-1:0] position;
      logic [CNT_W-1:0] extra_count;
      logic             end_of_stream;
   } req_type;

   typedef struct packed {
      logic [POS_W-1:0] out_position;
      logic [CNT_W-1:0] out_count;
      logic             out_last;
   } rsp_type;

   typedef struct packed {
      logic [WIN_W-1:0] gather_window;
      logic [CNT_W-1:0] seed_threshold;
      logic             gather_enable;
   } cfg_type;

   typedef struct packed {
      logic             open;
      logic [POS_W-1:0] head;
      logic [CNT_W-1:0] count;
   } clu_type;

   // Outcome of handing one merged record to the cluster stage.
   typedef struct packed {
      clu_type          clu;
      logic             close_vld;
      logic [POS_W-1:0] close_pos;
      logic [CNT_W-1:0] close_cnt;
      logic             pass_vld;
      logic [POS_W-1:0] pass_pos;
      logic [CNT_W-1:0] pass_cnt;
   } rel_type;

   function automatic logic [CNT_W-1:0] sat_add(input logic [CNT_W-1:0] a,
                                                 input logic [CNT_W-1:0] b);
      logic [CNT_W:0] s;
      s = {1'b0, a} + {1'b0, b};
      return s[CNT_W] ? CNT_MAX : s[CNT_W-1:0];
   endfunction

   function automatic rel_type release_rec(input clu_type          c,
                                           input logic [POS_W-1:0] pos,
                                           input logic [CNT_W-1:0] cnt,
                                           input cfg_type          cfg);
      rel_type          r;
      logic [POS_W-1:0] gap;
      logic             in_win;
      r           = '0;
      r.clu       = c;
      r.close_pos = c.head;
      r.close_cnt = c.count;
      r.pass_pos  = pos;
      r.pass_cnt  = cnt;
      gap         = pos - c.head;
      // A position below the head counts as outside the window.
      in_win      = c.open && (pos >= c.head) &&
                    (gap <= {{(POS_W-WIN_W){1'b0}}, cfg.gather_window});
      if (!cfg.gather_enable) begin
         if (c.open) begin
            r.close_vld = 1'b1;
            r.clu       = '0;
         end
         r.pass_vld = 1'b1;
      end else if (in_win) begin
         r.clu.count = sat_add(sat_add(c.count, cnt), {{(CNT_W-1){1'b0}}, 1'b1});
      end else begin
         if (c.open) begin
            r.close_vld = 1'b1;
            r.clu       = '0;
         end
         if (cnt >= cfg.seed_threshold) begin
            r.clu.open  = 1'b1;
            r.clu.head  = pos;
            r.clu.count = cnt;
         end else begin
            r.pass_vld = 1'b1;
         end
      end
      return r;
   endfunction

endpackage

`default_nettype wire

// ===== rtl/spdc_queue.sv =====
// ----------------------------------------------------------------------------
// spdc_queue
// Result queue: takes up to three results per cycle, hands out one per cycle unless stalled.
// ----------------------------------------------------------------------------
`default_nettype none

module spdc_queue (
   input  wire logic                         clock,
   input  wire logic                         reset,
   input  wire logic [spdc_pkg::PUSH_W-1:0]  push_cnt,
   input  wire spdc_pkg::rsp_type [spdc_pkg::MAX_PUSH-1:0] push_data,
   output logic                              room,
   output logic                              rsp_valid,
   input  wire logic                         rsp_stall,
   output spdc_pkg::rsp_type                 rsp_data
);
   import spdc_pkg::*;

   rsp_type            mem_ff [QUEUE_DEPTH];
   logic [QPTR_W-1:0]  wr_ptr_ff, wr_ptr_in;
   logic [QPTR_W-1:0]  rd_ptr_ff, rd_ptr_in;
   logic [QPTR_W:0]    count_ff, count_in;
   logic               pop;

   assign rsp_valid = (count_ff != '0);
   assign rsp_data  = mem_ff[rd_ptr_ff];
   assign pop       = rsp_valid && !rsp_stall;
   // Room for the largest burst one request can cause.
   assign room      = (count_ff <= (QPTR_W+1)'(QUEUE_DEPTH - MAX_PUSH));

   assign wr_ptr_in = wr_ptr_ff + QPTR_W'(push_cnt);
   assign rd_ptr_in = rd_ptr_ff + QPTR_W'(pop);
   assign count_in  = count_ff + (QPTR_W+1)'(push_cnt) - (QPTR_W+1)'(pop);

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      for (int i = 0; i < MAX_PUSH; i++) begin
         if (PUSH_W'(i) < push_cnt) begin
            mem_ff[wr_ptr_ff + QPTR_W'(i)] <= push_data[i];
         end
      end
   end

endmodule

`default_nettype wire

// ===== rtl/spdc_core.sv =====
// ----------------------------------------------------------------------------
// spdc_core
// Duplicate merge and cluster state; turns one request into up to three
// results in the cycle the request is taken.
// ----------------------------------------------------------------------------
`default_nettype none

module spdc_core (
   input  wire logic                         clock,
   input  wire logic                         reset,
   input  wire logic                         accept,
   input  wire spdc_pkg::req_type            req_data,
   input  wire spdc_pkg::cfg_type            cfg,
   output logic [spdc_pkg::PUSH_W-1:0]       push_cnt,
   output spdc_pkg::rsp_type [spdc_pkg::MAX_PUSH-1:0] push_data
);
   import spdc_pkg::*;

   clu_type            clu_ff, clu_in;
   logic               pv_ff, pv_in;
   logic [POS_W-1:0]   ppos_ff, ppos_in;
   logic [CNT_W-1:0]   pcnt_ff, pcnt_in;

   rel_type            ra, rb;
   logic [PUSH_W-1:0]  n;
   rsp_type [MAX_PUSH-1:0] res;

   always_comb begin
      clu_in  = clu_ff;
      pv_in   = pv_ff;
      ppos_in = ppos_ff;
      pcnt_in = pcnt_ff;
      ra      = '0;
      rb      = '0;
      n       = '0;
      res     = '0;
      if (accept) begin
         if (pv_ff && (req_data.position == ppos_ff)) begin
            // A duplicate adds one; its own count is dropped.
            pcnt_in = sat_add(pcnt_ff, {{(CNT_W-1){1'b0}}, 1'b1});
         end else begin
            if (pv_ff) begin
               ra     = release_rec(clu_ff, ppos_ff, pcnt_ff, cfg);
               clu_in = ra.clu;
               if (ra.close_vld) begin
                  res[n] = '{ra.close_pos, ra.close_cnt, 1'b0};
                  n      = n + 1'b1;
               end
               if (ra.pass_vld) begin
                  res[n] = '{ra.pass_pos, ra.pass_cnt, 1'b0};
                  n      = n + 1'b1;
               end
            end
            pv_in   = 1'b1;
            ppos_in = req_data.position;
            pcnt_in = req_data.extra_count;
         end
         if (req_data.end_of_stream) begin
            rb = release_rec(clu_in, ppos_in, pcnt_in, cfg);
            if (rb.close_vld) begin
               res[n] = '{rb.close_pos, rb.close_cnt, 1'b0};
               n      = n + 1'b1;
            end
            if (rb.pass_vld) begin
               res[n] = '{rb.pass_pos, rb.pass_cnt, 1'b0};
               n      = n + 1'b1;
            end
            if (rb.clu.open) begin
               res[n] = '{rb.clu.head, rb.clu.count, 1'b0};
               n      = n + 1'b1;
            end
            if (n != '0) begin
               res[n - 1'b1].out_last = 1'b1;
            end
            clu_in  = '0;
            pv_in   = 1'b0;
            ppos_in = '0;
            pcnt_in = '0;
         end
      end
   end

   assign push_cnt  = n;
   assign push_data = res;

   always_ff @(posedge clock) begin
      if (reset) begin
         clu_ff  <= '0;
         pv_ff   <= 1'b0;
         ppos_ff <= '0;
         pcnt_ff <= '0;
      end else begin
         clu_ff  <= clu_in;
         pv_ff   <= pv_in;
         ppos_ff <= ppos_in;
         pcnt_ff <= pcnt_in;
      end
   end

endmodule

`default_nettype wire

// ===== rtl/sorted_position_dedup_cluster.sv =====
// ----------------------------------------------------------------------------
// sorted_position_dedup_cluster
// A taken request writes its results to the result queue; if the queue was empty,
// the first is offered in the cycle after. Requests are taken one per cycle while
// the 8-entry result queue has room for three results; the queue drains one
// result per cycle while rsp_stall is low.
// Reset (synchronous) empties the queue and clears the merge and cluster state;
// the registers return to window 0, threshold 1, clustering enabled.
// ----------------------------------------------------------------------------
`default_nettype none

module sorted_position_dedup_cluster (
   input  wire logic                           clock,
   input  wire logic                           reset,
   input  wire logic                           req_valid,
   output logic                                req_stall,
   input  wire spdc_pkg::req_type              req_data,
   output logic                                rsp_valid,
   input  wire logic                           rsp_stall,
   output spdc_pkg::rsp_type                   rsp_data,
   input  wire logic                           csr_valid,
   output logic                                csr_ready,
   input  wire logic [spdc_pkg::CSR_IDX_W-1:0] csr_index,
   input  wire logic [spdc_pkg::WIN_W-1:0]     csr_data
);
   import spdc_pkg::*;

   cfg_type                cfg_ff, cfg_in;
   logic                   accept;
   logic                   room;
   logic [PUSH_W-1:0]      push_cnt;
   rsp_type [MAX_PUSH-1:0] push_data;

   assign csr_ready = 1'b1;
   assign req_stall = !room;
   assign accept    = req_valid && !req_stall;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_valid && csr_ready) begin
         unique case (csr_index)
            CSR_GATHER_WINDOW:  cfg_in.gather_window  = csr_data;
            CSR_SEED_THRESHOLD: cfg_in.seed_threshold = csr_data[CNT_W-1:0];
            CSR_GATHER_ENABLE:  cfg_in.gather_enable  = csr_data[0];
            default:            cfg_in = cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff <= '{gather_window: '0, seed_threshold: CNT_W'(1), gather_enable: 1'b1};
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   spdc_core u_core (
      .clock     (clock),
      .reset     (reset),
      .accept    (accept),
      .req_data  (req_data),
      .cfg       (cfg_ff),
      .push_cnt  (push_cnt),
      .push_data (push_data)
   );

   spdc_queue u_queue (
      .clock     (clock),
      .reset     (reset),
      .push_cnt  (push_cnt),
      .push_data (push_data),
      .room      (room),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_data  (rsp_data)
   );

endmodule

`default_nettype wire

// ===== rtl/spdc_checker.sv =====
// ----------------------------------------------------------------------------
// spdc_checker
// Port-level checks for the merge and cluster block, bound to the top level.
// ----------------------------------------------------------------------------
`default_nettype none

module spdc_checker (
   input  wire logic                           clock,
   input  wire logic                           reset,
   input  wire logic                           req_stall,
   input  wire logic                           rsp_valid,
   input  wire logic                           rsp_stall,
   input  wire spdc_pkg::rsp_type              rsp_data
);

   // Coming out of reset nothing is queued and requests are taken.
   a_reset_empty: assert property (@(posedge clock)
      reset |=> (!rsp_valid && !req_stall))
      else $error("queue not empty after reset");

   // An empty result queue always has room for another request.
   a_empty_room: assert property (@(posedge clock) disable iff (reset)
      !rsp_valid |-> !req_stall)
      else $error("request stalled with no result pending");

   // Space only frees up when a result leaves.
   a_stall_holds: assert property (@(posedge clock) disable iff (reset)
      (req_stall && !(rsp_valid && !rsp_stall)) |=> req_stall)
      else $error("request stall dropped without a result leaving");

   // A stalled result holds its value.
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_stall) |=> (rsp_valid && $stable(rsp_data)))
      else $error("stalled result changed");

endmodule

bind sorted_position_dedup_cluster spdc_checker u_spdc_checker (.*);

`default_nettype wire
